>>> rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and pipeline constants for the vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

   localparam int COMP_W      = 16;
   localparam int SUM_W       = 32;
   localparam int LEN_W       = 16;
   localparam int QUO_W       = 15;
   localparam int UNIT_SHIFT  = 14;
   localparam int LANES       = 3;

   localparam int SQRT_STEPS  = 16;
   localparam int DIV_STEPS   = UNIT_SHIFT + 1;
   // magnitude delay from the square stage to the divider entry
   localparam int MAG_DELAY   = SQRT_STEPS + 2;
   // abs, square, sum, root steps, quotient steps, merge
   localparam int PIPE_DEPTH  = 3 + SQRT_STEPS + DIV_STEPS + 1;

   localparam logic [LEN_W-1:0] EPS_RESET = 16'd1;

   typedef struct packed {
      logic signed [COMP_W-1:0] in_x;
      logic signed [COMP_W-1:0] in_y;
      logic signed [COMP_W-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] unit_x;
      logic signed [COMP_W-1:0] unit_y;
      logic signed [COMP_W-1:0] unit_z;
      logic [LEN_W-1:0]         length;
      logic                     too_small;
   } rsp_type;

   typedef struct packed {
      logic             neg;
      logic [QUO_W-1:0] quo;
   } lane_out_type;

endpackage

>>> rtl/vn_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// vn_sqrt_pipe
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vn_sqrt_pipe
   import vn_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [SUM_W-1:0] sum,
   output logic [LEN_W-1:0] root
);

   logic [SUM_W-1:0] n_ff    [SQRT_STEPS];
   logic [SUM_W-1:0] root_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [SUM_W-1:0] BIT_K = 32'h4000_0000 >> (2 * k);
      logic [SUM_W-1:0] n_p;
      logic [SUM_W-1:0] root_p;
      logic [SUM_W:0]   trial;
      logic [SUM_W-1:0] n_in;
      logic [SUM_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign n_p    = sum;
         assign root_p = '0;
      end else begin : g_next
         assign n_p    = n_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, root_p} + {1'b0, BIT_K};
         if ({1'b0, n_p} >= trial) begin
            n_in    = n_p - trial[SUM_W-1:0];
            root_in = (root_p >> 1) + BIT_K;
         end else begin
            n_in    = n_p;
            root_in = root_p >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]    <= n_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1][LEN_W-1:0];

endmodule

>>> rtl/vn_lane.sv
// ----------------------------------------------------------------------------
// vn_lane
// One component lane: magnitude, square, and a pipelined restoring divide
// of the magnitude scaled to Q1.14 by the vector length.
// ----------------------------------------------------------------------------
module vn_lane
   import vn_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [COMP_W-1:0] comp,
   input  logic [LEN_W-1:0]         len_in,
   output logic [SUM_W-1:0]         sq,
   output lane_out_type             result
);

   logic [COMP_W-1:0] abs_ff;
   logic              neg1_ff;
   logic [SUM_W-1:0]  sq_ff;
   logic [COMP_W-1:0] mag_d_ff [MAG_DELAY];
   logic              neg_d_ff [MAG_DELAY];

   logic [LEN_W-1:0]  rem_ff  [DIV_STEPS];
   logic [QUO_W-1:0]  quo_ff  [DIV_STEPS];
   logic [LEN_W-1:0]  dlen_ff [DIV_STEPS];
   logic              dneg_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         abs_ff      <= comp[COMP_W-1] ? COMP_W'(-comp) : COMP_W'(comp);
         neg1_ff     <= comp[COMP_W-1];
         sq_ff       <= SUM_W'(abs_ff) * SUM_W'(abs_ff);
         mag_d_ff[0] <= abs_ff;
         neg_d_ff[0] <= neg1_ff;
      end
   end

   for (genvar i = 1; i < MAG_DELAY; i++) begin : g_delay
      always_ff @(posedge clock) begin
         if (en) begin
            mag_d_ff[i] <= mag_d_ff[i-1];
            neg_d_ff[i] <= neg_d_ff[i-1];
         end
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [LEN_W-1:0] rem_p;
      logic             in_bit;
      logic [QUO_W-1:0] quo_p;
      logic [LEN_W-1:0] len_p;
      logic             neg_p;
      logic [LEN_W:0]   shifted;
      logic [LEN_W-1:0] rem_in;
      logic             q_bit;

      if (j == 0) begin : g_first
         assign rem_p  = {1'b0, mag_d_ff[MAG_DELAY-1][COMP_W-1:1]};
         assign in_bit = mag_d_ff[MAG_DELAY-1][0];
         assign quo_p  = '0;
         assign len_p  = len_in;
         assign neg_p  = neg_d_ff[MAG_DELAY-1];
      end else begin : g_next
         assign rem_p  = rem_ff[j-1];
         assign in_bit = 1'b0;
         assign quo_p  = quo_ff[j-1];
         assign len_p  = dlen_ff[j-1];
         assign neg_p  = dneg_ff[j-1];
      end

      always_comb begin
         shifted = {rem_p, in_bit};
         if (shifted >= {1'b0, len_p}) begin
            rem_in = LEN_W'(shifted - {1'b0, len_p});
            q_bit  = 1'b1;
         end else begin
            rem_in = shifted[LEN_W-1:0];
            q_bit  = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= {quo_p[QUO_W-2:0], q_bit};
            dlen_ff[j] <= len_p;
            dneg_ff[j] <= neg_p;
         end
      end
   end

   assign sq         = sq_ff;
   assign result.neg = dneg_ff[DIV_STEPS-1];
   assign result.quo = quo_ff[DIV_STEPS-1];

endmodule

>>> rtl/vn_merge.sv
// ----------------------------------------------------------------------------
// vn_merge
// Combines the lane quotients with the length: sign restore, threshold test
// and zeroing of short vectors.
// ----------------------------------------------------------------------------
module vn_merge
   import vn_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  lane_out_type     lanes [LANES],
   input  logic [LEN_W-1:0] len,
   input  logic [LEN_W-1:0] eps,
   output rsp_type          result
);

   rsp_type                  result_ff;
   rsp_type                  result_in;
   logic signed [COMP_W-1:0] unit [LANES];
   logic                     short_vec;

   always_comb begin
      short_vec = !(len > eps);
      for (int i = 0; i < LANES; i++) begin
         if (short_vec) begin
            unit[i] = '0;
         end else if (lanes[i].neg) begin
            unit[i] = -$signed(COMP_W'(lanes[i].quo));
         end else begin
            unit[i] = $signed(COMP_W'(lanes[i].quo));
         end
      end
      result_in.unit_x    = unit[0];
      result_in.unit_y    = unit[1];
      result_in.unit_z    = unit[2];
      result_in.length    = len;
      result_in.too_small = short_vec;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/vec3_normalize_core.sv
// ----------------------------------------------------------------------------
// vec3_normalize_core
// Normalizes a 3-component Q3.12 vector to Q1.14 and reports its length.
//
//   channel  direction  payload     handshake
//   req      in         req_type    req_valid / req_ready
//   rsp      out        rsp_type    rsp_valid / rsp_ready
//   csr      in         eps (16b)   csr_valid / csr_ready
//
// one item per cycle unless a held result fills the output and last stages;
// rsp_valid rises once the item has passed 36 register stages: abs, square,
// sum, 16 root steps, 15 quotient steps per lane, merge and the output register
// synchronous reset clears valid bits and sets the threshold to 1
// pipeline advances while its last stage is empty or can move into the
// output register, so items keep entering while a result waits
// ----------------------------------------------------------------------------
module vec3_normalize_core
   import vn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_wdata
);

   logic [LEN_W-1:0]      eps_ff;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic                  adv;
   logic                  out_load;
   logic                  out_valid_ff;
   rsp_type               out_ff;

   logic signed [COMP_W-1:0] comp [LANES];
   logic [SUM_W-1:0]         sq   [LANES];
   lane_out_type             lane_res [LANES];
   logic [SUM_W-1:0]         sum_ff;
   logic [LEN_W-1:0]         root;
   logic [LEN_W-1:0]         len_d_ff [DIV_STEPS];
   rsp_type                  merged;

   assign adv       = !valid_ff[PIPE_DEPTH-1] || !out_valid_ff || rsp_ready;
   assign out_load  = valid_ff[PIPE_DEPTH-1] && (!out_valid_ff || rsp_ready);
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= EPS_RESET;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            eps_ff <= csr_wdata;
         end
         if (adv) begin
            valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign comp[0] = req_data.in_x;
   assign comp[1] = req_data.in_y;
   assign comp[2] = req_data.in_z;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      vn_lane u_lane (
         .clock  (clock),
         .en     (adv),
         .comp   (comp[i]),
         .len_in (root),
         .sq     (sq[i]),
         .result (lane_res[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff      <= sq[0] + sq[1] + sq[2];
         len_d_ff[0] <= root;
      end
   end

   for (genvar i = 1; i < DIV_STEPS; i++) begin : g_len
      always_ff @(posedge clock) begin
         if (adv) begin
            len_d_ff[i] <= len_d_ff[i-1];
         end
      end
   end

   vn_sqrt_pipe u_sqrt (
      .clock (clock),
      .en    (adv),
      .sum   (sum_ff),
      .root  (root)
   );

   vn_merge u_merge (
      .clock  (clock),
      .en     (adv),
      .lanes  (lane_res),
      .len    (len_d_ff[DIV_STEPS-1]),
      .eps    (eps_ff),
      .result (merged)
   );

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= merged;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_zero_when_small: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_small |->
         rsp_data.unit_x == 0 && rsp_data.unit_y == 0 && rsp_data.unit_z == 0)
      else $error("short vector result not zeroed");

   a_len_above_eps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.too_small |-> rsp_data.length > eps_ff)
      else $error("unit vector given for length at or below threshold");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.unit_x <= 16384 && rsp_data.unit_x >= -16384 &&
         rsp_data.unit_y <= 16384 && rsp_data.unit_y >= -16384 &&
         rsp_data.unit_z <= 16384 && rsp_data.unit_z >= -16384)
      else $error("unit component out of range");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> out_valid_ff && valid_ff[PIPE_DEPTH-1] && !rsp_ready)
      else $error("input stalled while pipeline could advance");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for vec3_normalize_core. A short table of directed vectors and
// thresholds is followed by random vectors under several thresholds and
// three idling patterns on the req and rsp channels. Each accepted item is
// predicted by a local length and quotient model, or by the table if pinned,
// and each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import vn_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_HOLD  = 64;
   localparam int SHOW_MAX    = 10;

   typedef struct packed {
      logic             wr;
      logic [LEN_W-1:0] thr;
      req_type          vec;
      logic             pin;
      rsp_type          exp;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_wdata = '0;

   logic             pin_use = 1'b0;
   rsp_type          pin_rsp = '0;

   logic [LEN_W-1:0] eps_model = EPS_RESET;
   rsp_type          unit_q [$];
   dir_row_type      dir_rows [$];
   int               snd_pct = 0;
   int               rcv_pct = 0;
   int               errs = 0;
   int               cycles = 0;

   vec3_normalize_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] comp_mag(logic signed [COMP_W-1:0] c);
      int t;
      t = c;
      if (t < 0) t = -t;
      return 32'(t);
   endfunction

   function automatic logic [COMP_W-1:0] unit_lane(logic signed [COMP_W-1:0] c,
                                                   logic [31:0] len);
      logic [31:0] q;
      q = (comp_mag(c) << UNIT_SHIFT) / len;
      if (c < 0) q = 32'd0 - q;
      return q[COMP_W-1:0];
   endfunction

   function automatic rsp_type unit_expect(req_type v, logic [LEN_W-1:0] thr);
      logic [31:0] rem;
      logic [31:0] root;
      logic [31:0] bitv;
      rsp_type     r;
      rem = comp_mag(v.in_x) * comp_mag(v.in_x) + comp_mag(v.in_y) * comp_mag(v.in_y)
          + comp_mag(v.in_z) * comp_mag(v.in_z);
      root = 32'd0;
      bitv = 32'd1 << 30;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 32'd0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      r = '0;
      r.length = root[LEN_W-1:0];
      if (root > 32'(thr)) begin
         r.unit_x = unit_lane(v.in_x, root);
         r.unit_y = unit_lane(v.in_y, root);
         r.unit_z = unit_lane(v.in_z, root);
      end else begin
         r.too_small = 1'b1;
      end
      return r;
   endfunction

   task automatic add_row(input logic wr, input int thr, input int x, input int y,
                          input int z, input logic pin, input int ux, input int uy,
                          input int uz, input int len, input logic ts);
      dir_row_type r;
      r.wr            = wr;
      r.thr           = LEN_W'(thr);
      r.vec.in_x      = COMP_W'(x);
      r.vec.in_y      = COMP_W'(y);
      r.vec.in_z      = COMP_W'(z);
      r.pin           = pin;
      r.exp.unit_x    = COMP_W'(ux);
      r.exp.unit_y    = COMP_W'(uy);
      r.exp.unit_z    = COMP_W'(uz);
      r.exp.length    = LEN_W'(len);
      r.exp.too_small = ts;
      dir_rows.push_back(r);
   endtask

   task automatic send_item(input req_type v, input logic pin, input rsp_type exp);
      if ($urandom_range(0, 99) < snd_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < snd_pct);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      pin_use   <= pin;
      pin_rsp   <= exp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (unit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   task automatic write_eps(input logic [LEN_W-1:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      eps_model = val;
   endtask

   // result check against the oldest prediction
   always @(posedge clock) begin : mon
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rcv_pct);
         if (!reset) begin
            if (req_valid && req_ready) begin
               unit_q.push_back(pin_use ? pin_rsp : unit_expect(req_data, eps_model));
            end
            if (rsp_valid && rsp_ready) begin
               if (unit_q.size() == 0) begin
                  errs <= errs + 1;
                  if (errs < SHOW_MAX) begin
                     $display("unexpected item: x %0d y %0d z %0d len %0d small %0b",
                              rsp_data.unit_x, rsp_data.unit_y, rsp_data.unit_z,
                              rsp_data.length, rsp_data.too_small);
                  end
               end else begin
                  want = unit_q.pop_front();
                  if (rsp_data.unit_x !== want.unit_x || rsp_data.unit_y !== want.unit_y ||
                      rsp_data.unit_z !== want.unit_z || rsp_data.length !== want.length ||
                      rsp_data.too_small !== want.too_small) begin
                     errs <= errs + 1;
                     if (errs < SHOW_MAX) begin
                        $display("mismatch exp x %0d y %0d z %0d len %0d small %0b",
                                 want.unit_x, want.unit_y, want.unit_z, want.length,
                                 want.too_small);
                        $display("         got x %0d y %0d z %0d len %0d small %0b",
                                 rsp_data.unit_x, rsp_data.unit_y, rsp_data.unit_z,
                                 rsp_data.length, rsp_data.too_small);
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      req_type          v;
      logic [COMP_W-1:0] c [3];
      logic [LEN_W-1:0] thr;
      int               kind;
      int               m;

      // threshold at reset value 1 for the first rows
      add_row(0, 0,      0,      0,      0,     1,      0,      0,      0,     0, 1);
      add_row(0, 0,      1,      0,      0,     1,      0,      0,      0,     1, 1);
      add_row(0, 0,      2,      0,      0,     1,  16384,      0,      0,     2, 0);
      add_row(0, 0,   4096,      0,      0,     1,  16384,      0,      0,  4096, 0);
      add_row(0, 0,  -4096,      0,      0,     1, -16384,      0,      0,  4096, 0);
      add_row(0, 0,      0,  32767,      0,     1,      0,  16384,      0, 32767, 0);
      add_row(0, 0,      0,      0, -32768,     1,      0,      0, -16384, 32768, 0);
      add_row(0, 0, -32768, -32768, -32768,     0,      0,      0,      0,     0, 0);
      add_row(0, 0,  32767,  32767,  32767,     0,      0,      0,      0,     0, 0);
      add_row(0, 0,      3,      4,    -12,     0,      0,      0,      0,     0, 0);
      // zero threshold
      add_row(1, 0,      0,      0,      0,     1,      0,      0,      0,     0, 1);
      add_row(0, 0,      1,      0,      0,     1,  16384,      0,      0,     1, 0);
      add_row(0, 0,      0,     -1,      0,     1,      0, -16384,      0,     1, 0);
      // top threshold flags everything, length still reported
      add_row(1, 65535, -32768, -32768, -32768, 1,  0,      0,      0, 56755, 1);
      add_row(0, 0,  32767, -32768,      1,     0,      0,      0,      0,     0, 0);
      // threshold boundary
      add_row(1, 4095,  4096,      0,      0,   1,  16384,      0,      0,  4096, 0);
      add_row(1, 4096,  4096,      0,      0,   1,      0,      0,      0,  4096, 1);
      add_row(0, 0,      0,      0,   4097,     1,      0,      0,  16384,  4097, 0);
      add_row(0, 0,  21845, -21846,  12345,     0,      0,      0,      0,     0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_pct = 32;
      rcv_pct = 65;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].wr) write_eps(dir_rows[i].thr);
         send_item(dir_rows[i].vec, dir_rows[i].pin, dir_rows[i].exp);
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin snd_pct = 32; rcv_pct = 65; end
            1: begin snd_pct = 65; rcv_pct = 32; end
            default: begin snd_pct = 0; rcv_pct = 0; end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            case (seg)
               0: thr = (mode == 2) ? EPS_RESET : '0;
               1: thr = LEN_W'($urandom_range(0, 64));
               2: thr = LEN_W'($urandom_range(0, 8192));
               default: thr = (mode == 0) ? 16'hFFFF : LEN_W'($urandom_range(0, 65535));
            endcase
            write_eps(thr);
            for (int n = 0; n < 128; n++) begin
               kind = $urandom_range(0, 9);
               for (int j = 0; j < 3; j++) begin
                  case (kind)
                     0, 1, 2, 3: c[j] = COMP_W'($urandom);
                     4, 5: c[j] = COMP_W'(int'($urandom_range(0, 24)) - 12);
                     6: begin
                        case ($urandom_range(0, 4))
                           0: c[j] = 16'h8000;
                           1: c[j] = 16'h7FFF;
                           2: c[j] = 16'h0000;
                           3: c[j] = 16'hFFFF;
                           default: c[j] = 16'h0001;
                        endcase
                     end
                     7: c[j] = (j == 0) ? COMP_W'($urandom) : '0;
                     8: c[j] = COMP_W'(int'($urandom_range(0, 8191)) - 4096);
                     default: begin
                        // single axis straddling the threshold
                        m = int'(eps_model) + int'($urandom_range(0, 2)) - 1;
                        if (m > 32767) m = 32767;
                        if (m < 0) m = 0;
                        if ($urandom_range(0, 1)) m = -m;
                        c[j] = (j == 2) ? COMP_W'(m) : '0;
                     end
                  endcase
               end
               v.in_x = c[0];
               v.in_y = c[1];
               v.in_z = c[2];
               send_item(v, 1'b0, '0);
               if ($urandom_range(0, 299) == 0) wait_drained();
            end
         end
      end

      wait_drained();
      if (errs == 0 && unit_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> vec3_normalize_core.f
rtl/vn_pkg.sv
rtl/vn_sqrt_pipe.sv
rtl/vn_lane.sv
rtl/vn_merge.sv
rtl/vec3_normalize_core.sv
sim/tb_top.sv
